FILE: hdl/dara_pkg.sv
package dara_pkg;

   // Table sizes and count width
   localparam int NUM_CUSTOMERS = 5;
   localparam int NUM_RESOURCES = 4;
   localparam int COUNT_WIDTH   = 8;

   // Port geometry, fixed by the word format
   localparam int CUST_W   = 3;
   localparam int AMT_W    = 8;
   localparam int AVAIL_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W    = 32;
   localparam int NUM_PORTS = 4;

   // Derived widths
   localparam int CIDX_W = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
   localparam int CMP_W  = ((COUNT_WIDTH > AMT_W) ? COUNT_WIDTH : AMT_W) + 1;
   localparam int WORK_W = COUNT_WIDTH + $clog2(NUM_CUSTOMERS + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLAIM_LAST = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_AVAIL = CSR_IDX_W'(5);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DENIED   = 2'd1,
      STATUS_BAD_CUST = 2'd2
   } status_type;

   typedef logic [COUNT_WIDTH-1:0]               count_type;
   typedef count_type [NUM_RESOURCES-1:0]        cvec_type;
   typedef cvec_type [NUM_CUSTOMERS-1:0]         ctab_type;
   typedef logic [WORK_W-1:0]                    work_type;
   typedef work_type [NUM_RESOURCES-1:0]         wvec_type;

   // Safety checker status back to the sequencer
   typedef struct packed {
      logic done;
      logic safe;
   } chk_type;

   // Split a packed register word into per-resource counts
   function automatic cvec_type unpack_counts(input logic [CSR_W-1:0] word);
      cvec_type        v;
      logic [CSR_W-1:0] s;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         s    = word >> (r * COUNT_WIDTH);
         v[r] = s[COUNT_WIDTH-1:0];
      end
      return v;
   endfunction

   // Low byte of a count, zero-extended when the count is narrower
   function automatic logic [AVAIL_W-1:0] to_byte(input count_type c);
      logic [CMP_W-1:0] w;
      w = CMP_W'(c);
      return w[AVAIL_W-1:0];
   endfunction

endpackage

FILE: hdl/deadlock_avoiding_resource_allocator.sv
// Banker's-algorithm allocator with four resources and five customers. A word is taken
// when start is high and busy is low; its single result appears on the rsp_ ports for
// exactly one cycle with rsp_strobe high, and the receiver cannot stall it. A release,
// an invalid customer or a request failing the claim or free-count check goes from acceptance
// through evaluate and respond back to idle. A request that passes those checks is applied
// and run through the safety checker, which finishes at most one customer per cycle. An
// unsafe request is rolled back and reported denied. Configuration words are taken while
// busy is low; writing initial_available reloads the free counts and clears every
// allocation.
module deadlock_avoiding_resource_allocator import dara_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_type,
   input  logic [CUST_W-1:0]    req_customer,
   input  logic [AMT_W-1:0]     req_amount_0,
   input  logic [AMT_W-1:0]     req_amount_1,
   input  logic [AMT_W-1:0]     req_amount_2,
   input  logic [AMT_W-1:0]     req_amount_3,
   output logic                 rsp_strobe,
   output logic [1:0]           rsp_status,
   output logic [AVAIL_W-1:0]   rsp_avail_0,
   output logic [AVAIL_W-1:0]   rsp_avail_1,
   output logic [AVAIL_W-1:0]   rsp_avail_2,
   output logic [AVAIL_W-1:0]   rsp_avail_3,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_SAFE = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   typedef logic [AMT_W-1:0] amt_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   cvec_type   avail_ff, avail_in;
   ctab_type   alloc_ff, alloc_in;
   ctab_type   claim_ff, claim_in;
   logic       type_ff;
   logic [CUST_W-1:0] cust_ff;
   amt_type [NUM_RESOURCES-1:0] amt_ff;

   amt_type [NUM_PORTS-1:0]     amt_port;
   logic [NUM_PORTS-1:0][AVAIL_W-1:0] avail_byte;
   logic [CIDX_W-1:0]           cidx;
   logic                        cust_bad;
   logic                        req_ok;
   logic                        chk_start;
   chk_type                     chk;
   logic                        csr_fire;
   logic [CMP_W-1:0]            sum_w;
   logic [CMP_W-1:0]            give_w;
   logic [COUNT_WIDTH:0]        rel_sum;

   assign amt_port = {req_amount_3, req_amount_2, req_amount_1, req_amount_0};
   assign cidx     = cust_ff[CIDX_W-1:0];
   assign cust_bad = (32'(cust_ff) >= NUM_CUSTOMERS);
   assign busy     = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_fire = csr_valid && csr_ready;

   // Check a request against the claim and the free counts
   always_comb begin
      req_ok = 1'b1;
      sum_w  = '0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         sum_w = CMP_W'(alloc_ff[cidx][r]) + CMP_W'(amt_ff[r]);
         if (sum_w > CMP_W'(claim_ff[cidx][r])) begin
            req_ok = 1'b0;
         end
         if (CMP_W'(amt_ff[r]) > CMP_W'(avail_ff[r])) begin
            req_ok = 1'b0;
         end
      end
   end

   // Sequence one word: evaluate, run the safety check for a passing request, respond; take register writes while idle
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      avail_in  = avail_ff;
      alloc_in  = alloc_ff;
      claim_in  = claim_ff;
      chk_start = 1'b0;
      give_w    = '0;
      rel_sum   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_fire) begin
               if (csr_index <= CSR_CLAIM_LAST) begin
                  if (32'(csr_index) < NUM_CUSTOMERS) begin
                     claim_in[csr_index[CIDX_W-1:0]] = unpack_counts(csr_data);
                  end
               end else if (csr_index == CSR_INIT_AVAIL) begin
                  avail_in = unpack_counts(csr_data);
                  alloc_in = '0;
               end
            end
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_RESP;
            if (cust_bad) begin
               status_in = STATUS_BAD_CUST;
            end else if (type_ff) begin
               // Release: clamp to holdings, saturate the free count
               status_in = STATUS_OK;
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  give_w = (CMP_W'(amt_ff[r]) < CMP_W'(alloc_ff[cidx][r])) ?
                           CMP_W'(amt_ff[r]) : CMP_W'(alloc_ff[cidx][r]);
                  rel_sum = (COUNT_WIDTH+1)'(avail_ff[r]) +
                            (COUNT_WIDTH+1)'(give_w[COUNT_WIDTH-1:0]);
                  alloc_in[cidx][r] = alloc_ff[cidx][r] - give_w[COUNT_WIDTH-1:0];
                  avail_in[r] = rel_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} :
                                rel_sum[COUNT_WIDTH-1:0];
               end
            end else if (!req_ok) begin
               status_in = STATUS_DENIED;
            end else begin
               // Apply tentatively and start the safety check
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  avail_in[r] = avail_ff[r] - COUNT_WIDTH'(amt_ff[r]);
                  alloc_in[cidx][r] = alloc_ff[cidx][r] + COUNT_WIDTH'(amt_ff[r]);
               end
               chk_start = 1'b1;
               state_in  = ST_SAFE;
            end
         end
         ST_SAFE: begin
            if (chk.done) begin
               state_in = ST_RESP;
               if (chk.safe) begin
                  status_in = STATUS_OK;
               end else begin
                  // Roll the request back
                  status_in = STATUS_DENIED;
                  for (int r = 0; r < NUM_RESOURCES; r++) begin
                     avail_in[r] = avail_ff[r] + COUNT_WIDTH'(amt_ff[r]);
                     alloc_in[cidx][r] = alloc_ff[cidx][r] - COUNT_WIDTH'(amt_ff[r]);
                  end
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dara_safety u_safety (
      .clock      (clock),
      .reset      (reset),
      .chk_start  (chk_start),
      .init_avail (avail_in),
      .alloc      (alloc_ff),
      .claim      (claim_ff),
      .chk        (chk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         avail_ff <= '0;
         alloc_ff <= '0;
         claim_ff <= '0;
      end else begin
         state_ff <= state_in;
         avail_ff <= avail_in;
         alloc_ff <= alloc_in;
         claim_ff <= claim_in;
      end
   end

   // Capture the word on acceptance
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (state_ff == ST_IDLE && start) begin
         type_ff <= req_type;
         cust_ff <= req_customer;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            amt_ff[r] <= amt_port[r];
         end
      end
   end

   // Drive the result, zero for unused resources
   always_comb begin
      avail_byte = '0;
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         avail_byte[r] = to_byte(avail_ff[r]);
      end
   end

   assign rsp_strobe  = (state_ff == ST_RESP);
   assign rsp_status  = status_ff;
   assign rsp_avail_0 = avail_byte[0];
   assign rsp_avail_1 = avail_byte[1];
   assign rsp_avail_2 = avail_byte[2];
   assign rsp_avail_3 = avail_byte[3];

endmodule

FILE: hdl/dara_safety.sv
module dara_safety import dara_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     chk_start,
   input  cvec_type init_avail,
   input  ctab_type alloc,
   input  ctab_type claim,
   output chk_type  chk
);

   wvec_type                 work_ff, work_in;
   logic [NUM_CUSTOMERS-1:0] done_ff, done_in;
   logic                     run_ff, run_in;

   logic [NUM_CUSTOMERS-1:0] fits;
   logic [NUM_CUSTOMERS-1:0] pick_hot;
   logic [CIDX_W-1:0]        pick;
   logic                     found;
   logic                     all_done;
   count_type                need;

   // Test every unfinished customer's need against the work vector
   always_comb begin
      fits = '0;
      need = '0;
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
         fits[c] = !done_ff[c];
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            need = (claim[c][r] > alloc[c][r]) ? count_type'(claim[c][r] - alloc[c][r]) : '0;
            if (WORK_W'(need) > work_ff[r]) begin
               fits[c] = 1'b0;
            end
         end
      end
   end

   // Pick the lowest-numbered customer that fits
   always_comb begin
      found    = 1'b0;
      pick     = '0;
      pick_hot = '0;
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
         if (fits[c] && !found) begin
            found       = 1'b1;
            pick        = CIDX_W'(c);
            pick_hot[c] = 1'b1;
         end
      end
   end

   assign all_done = ((done_ff | pick_hot) == {NUM_CUSTOMERS{1'b1}});

   // Finish the picked customer: return its holdings to the work vector
   always_comb begin
      work_in = work_ff;
      done_in = done_ff;
      run_in  = run_ff;
      if (chk_start) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_in[r] = WORK_W'(init_avail[r]);
         end
         done_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            work_in[r] = work_ff[r] + WORK_W'(alloc[pick][r]);
         end
         done_in = done_ff | pick_hot;
         if (!found || all_done) begin
            run_in = 1'b0;
         end
      end
   end

   assign chk.done = run_ff && (!found || all_done);
   assign chk.safe = found;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      done_ff <= done_in;
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import dara_pkg::*;

   localparam logic REQ_ACQUIRE = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAIM_C0 = CSR_IDX_W'(0);

   typedef struct packed {
      logic                                kind;
      logic [CUST_W-1:0]                   cust;
      logic [NUM_RESOURCES-1:0][AMT_W-1:0] amt;
   } word_type;

   typedef struct packed {
      status_type                            status;
      logic [NUM_RESOURCES-1:0][AVAIL_W-1:0] avail;
   } outcome_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_type = REQ_ACQUIRE;
   logic [CUST_W-1:0]    req_customer = '0;
   logic [AMT_W-1:0]     req_amount_0 = '0;
   logic [AMT_W-1:0]     req_amount_1 = '0;
   logic [AMT_W-1:0]     req_amount_2 = '0;
   logic [AMT_W-1:0]     req_amount_3 = '0;
   logic                 rsp_strobe;
   logic [1:0]           rsp_status;
   logic [AVAIL_W-1:0]   rsp_avail_0;
   logic [AVAIL_W-1:0]   rsp_avail_1;
   logic [AVAIL_W-1:0]   rsp_avail_2;
   logic [AVAIL_W-1:0]   rsp_avail_3;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;

   deadlock_avoiding_resource_allocator u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_customer (req_customer),
      .req_amount_0 (req_amount_0),
      .req_amount_1 (req_amount_1),
      .req_amount_2 (req_amount_2),
      .req_amount_3 (req_amount_3),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_avail_0  (rsp_avail_0),
      .rsp_avail_1  (rsp_avail_1),
      .rsp_avail_2  (rsp_avail_2),
      .rsp_avail_3  (rsp_avail_3),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Allocator state as the testbench tracks it
   logic [CSR_W-1:0] claim_reg [NUM_CUSTOMERS];
   int               free_cnt  [NUM_RESOURCES];
   int               held      [NUM_CUSTOMERS][NUM_RESOURCES];

   word_type    queued_words[$];
   outcome_type pending_outcomes[$];
   word_type    on_bus;
   int          gap_left;
   bit          gapless;
   int          n_queued;
   int          n_taken;
   int          n_errors;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int claim_of(input int c, input int r);
      return int'(claim_reg[c][r*COUNT_WIDTH +: COUNT_WIDTH]);
   endfunction

   function automatic int need_of(input int c, input int r);
      int m;
      m = claim_of(c, r);
      return (m > held[c][r]) ? m - held[c][r] : 0;
   endfunction

   function automatic void clear_model();
      for (int c = 0; c < NUM_CUSTOMERS; c++) begin
         claim_reg[c] = '0;
         for (int r = 0; r < NUM_RESOURCES; r++) held[c][r] = 0;
      end
      for (int r = 0; r < NUM_RESOURCES; r++) free_cnt[r] = 0;
   endfunction

   // Track a register write; the pool word reloads free counts and drops allocations
   function automatic void load_register(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [CSR_W-1:0] val);
      if (idx == CSR_INIT_AVAIL) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            free_cnt[r] = int'(val[r*COUNT_WIDTH +: COUNT_WIDTH]);
            for (int c = 0; c < NUM_CUSTOMERS; c++) held[c][r] = 0;
         end
      end else if (idx <= CSR_CLAIM_LAST) begin
         claim_reg[idx - CSR_CLAIM_C0] = val;
      end
   endfunction

   // Finish the lowest-numbered customer whose need fits, until none is left
   function automatic bit pool_is_safe();
      int work [NUM_RESOURCES];
      bit done [NUM_CUSTOMERS];
      int pick;
      bit fits;
      for (int r = 0; r < NUM_RESOURCES; r++) work[r] = free_cnt[r];
      for (int c = 0; c < NUM_CUSTOMERS; c++) done[c] = 1'b0;
      for (int round = 0; round < NUM_CUSTOMERS; round++) begin
         pick = -1;
         for (int c = 0; c < NUM_CUSTOMERS && pick < 0; c++) begin
            fits = !done[c];
            for (int r = 0; r < NUM_RESOURCES; r++)
               if (need_of(c, r) > work[r]) fits = 1'b0;
            if (fits) pick = c;
         end
         if (pick < 0) return 1'b0;
         done[pick] = 1'b1;
         for (int r = 0; r < NUM_RESOURCES; r++) work[r] += held[pick][r];
      end
      return 1'b1;
   endfunction

   // Apply one word to the tracked pool and return the result it must produce
   function automatic outcome_type allocate_or_free(input word_type w);
      outcome_type o;
      int          c;
      int          give;
      bit          ok;
      c = int'(w.cust);
      if (c >= NUM_CUSTOMERS) begin
         o.status = STATUS_BAD_CUST;
      end else if (w.kind == REQ_ACQUIRE) begin
         ok = 1'b1;
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (held[c][r] + int'(w.amt[r]) > claim_of(c, r)) ok = 1'b0;
            if (int'(w.amt[r]) > free_cnt[r]) ok = 1'b0;
         end
         if (ok) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               free_cnt[r] -= int'(w.amt[r]);
               held[c][r]  += int'(w.amt[r]);
            end
            // roll back a grant that leaves the pool unsafe
            if (!pool_is_safe()) begin
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  free_cnt[r] += int'(w.amt[r]);
                  held[c][r]  -= int'(w.amt[r]);
               end
               ok = 1'b0;
            end
         end
         o.status = ok ? STATUS_OK : STATUS_DENIED;
      end else begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            give = (int'(w.amt[r]) < held[c][r]) ? int'(w.amt[r]) : held[c][r];
            held[c][r] -= give;
            free_cnt[r] += give;
            if (free_cnt[r] > (1 << COUNT_WIDTH) - 1) free_cnt[r] = (1 << COUNT_WIDTH) - 1;
         end
         o.status = STATUS_OK;
      end
      for (int r = 0; r < NUM_RESOURCES; r++) o.avail[r] = AVAIL_W'(free_cnt[r]);
      return o;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (gapless) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // Drive words from the queue; hold each until taken, then idle for its gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            pending_outcomes.push_back(allocate_or_free(on_bus));
            n_taken++;
         end
         if (start && busy) begin
            // hold the current word
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (queued_words.size() > 0) begin
            on_bus = queued_words.pop_front();
            req_type     <= on_bus.kind;
            req_customer <= on_bus.cust;
            req_amount_0 <= on_bus.amt[0];
            req_amount_1 <= on_bus.amt[1];
            req_amount_2 <= on_bus.amt[2];
            req_amount_3 <= on_bus.amt[3];
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_errors++;
      end
   endtask

   // Match each result word against the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result word, status %0d", rsp_status);
            n_errors++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", int'(want.status), int'(rsp_status));
            check_field("avail_0", int'(want.avail[0]), int'(rsp_avail_0));
            check_field("avail_1", int'(want.avail[1]), int'(rsp_avail_1));
            check_field("avail_2", int'(want.avail[2]), int'(rsp_avail_2));
            check_field("avail_3", int'(want.avail[3]), int'(rsp_avail_3));
         end
      end
   end

   function automatic void queue_word(input logic kind, input int cust,
                                      input int a0, input int a1, input int a2, input int a3);
      word_type w;
      w.kind   = kind;
      w.cust   = CUST_W'(cust);
      w.amt[0] = AMT_W'(a0);
      w.amt[1] = AMT_W'(a1);
      w.amt[2] = AMT_W'(a2);
      w.amt[3] = AMT_W'(a3);
      queued_words.push_back(w);
      n_queued++;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      load_register(idx, val);
   endtask

   // Wait until every word is taken and answered, then let the block settle
   task automatic drain();
      while (n_taken != n_queued || pending_outcomes.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Small amount up to a cap, now and then a full-range byte
   function automatic int pick_amount(input int cap);
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, (cap < 6) ? cap : 6);
   endfunction

   function automatic void queue_random_word();
      int roll;
      int c;
      roll = $urandom_range(0, 99);
      c    = $urandom_range(0, NUM_CUSTOMERS - 1);
      if (roll < 60) begin
         queue_word(REQ_ACQUIRE, c, pick_amount(claim_of(c, 0)), pick_amount(claim_of(c, 1)),
                    pick_amount(claim_of(c, 2)), pick_amount(claim_of(c, 3)));
      end else if (roll < 90) begin
         if ($urandom_range(0, 4) == 0)
            queue_word(REQ_RELEASE, c, 255, 255, 255, 255);
         else
            queue_word(REQ_RELEASE, c, $urandom_range(0, 5), $urandom_range(0, 5),
                       $urandom_range(0, 5), $urandom_range(0, 5));
      end else if (roll < 95) begin
         queue_word(1'($urandom_range(0, 1)), $urandom_range(NUM_CUSTOMERS, 7),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
         queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 7),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endfunction

   function automatic logic [CSR_W-1:0] random_pool_word();
      logic [CSR_W-1:0] v;
      for (int r = 0; r < NUM_RESOURCES; r++)
         v[r*COUNT_WIDTH +: COUNT_WIDTH] = ($urandom_range(0, 3) == 0) ?
            COUNT_WIDTH'($urandom_range(0, 255)) : COUNT_WIDTH'($urandom_range(0, 12));
      return v;
   endfunction

   initial begin
      logic [CSR_W-1:0] claim_val;
      logic [CSR_W-1:0] pool_val;
      clear_model();
      n_queued = 0;
      n_taken  = 0;
      n_errors = 0;
      gapless  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Everything zero after reset: only empty acquire requests pass
      queue_word(REQ_ACQUIRE, 0, 0, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 1, 1, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 7, 255, 255, 255, 255);
      queue_word(REQ_RELEASE, 5, 0, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 6, 1, 2, 3, 4);
      queue_word(REQ_RELEASE, 4, 255, 255, 255, 255);
      drain();

      // Small pool with one customer able to take all of it
      write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(0), 32'h0000_0003);
      write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(1), 32'h0000_0003);
      write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(2), 32'h010A_0500);
      write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(3), 32'hFF0A_0503);
      write_reg(CSR_CLAIM_LAST, 32'h0000_0000);
      write_reg(CSR_INIT_AVAIL, 32'hFF0A_0503);
      queue_word(REQ_ACQUIRE, 0, 2, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 1, 1, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 0, 2, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 2, 0, 6, 0, 0);
      queue_word(REQ_ACQUIRE, 2, 0, 5, 10, 1);
      queue_word(REQ_ACQUIRE, 4, 0, 0, 0, 0);
      queue_word(REQ_RELEASE, 0, 255, 255, 255, 255);
      queue_word(REQ_RELEASE, 2, 0, 2, 0, 0);
      queue_word(REQ_ACQUIRE, 3, 3, 2, 0, 254);
      queue_word(REQ_ACQUIRE, 3, 255, 255, 255, 255);
      drain();

      // Drop a claim below what the customer already holds
      write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(2), 32'h0000_0000);
      queue_word(REQ_ACQUIRE, 2, 0, 0, 0, 0);
      queue_word(REQ_ACQUIRE, 2, 0, 0, 0, 1);
      queue_word(REQ_RELEASE, 2, 0, 3, 10, 1);
      queue_word(REQ_ACQUIRE, 2, 0, 0, 0, 0);
      drain();

      // Random phases, each under its own claims; the pool is reloaded in the first two and at random after
      for (int p = 0; p < 8; p++) begin
         gapless = (p % 3 == 2);
         for (int c = 0; c < NUM_CUSTOMERS; c++) begin
            if (p == 0)
               claim_val = '1;
            else if (p == 1)
               claim_val = '0;
            else
               claim_val = random_pool_word();
            write_reg(CSR_CLAIM_C0 + CSR_IDX_W'(c), claim_val);
         end
         if (p < 2 || $urandom_range(0, 2) != 0) begin
            pool_val = (p == 0) ? '1 : (p == 1) ? '0 : random_pool_word();
            write_reg(CSR_INIT_AVAIL, pool_val);
         end
         for (int i = 0; i < 75; i++) queue_random_word();
         drain();
      end

      if (n_errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
